FILE: rtl/acl_pkg.sv
//------------------------------------------------------------------------------
// acl_pkg
// Shared types, token codes, lexer modes and the keyword table.
//------------------------------------------------------------------------------
`default_nettype none

package acl_pkg;

    localparam int MAX_TOKEN_LEN   = 2048;
    localparam int KEYWORD_MAX_LEN = 10;
    localparam int LEN_W           = $clog2(MAX_TOKEN_LEN) + 1;
    localparam int NB_IDX_W        = $clog2(KEYWORD_MAX_LEN);
    localparam int KEY_W           = 8 * KEYWORD_MAX_LEN;
    localparam int KLEN_W          = $clog2(KEYWORD_MAX_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_LEN - 1);

    // configuration register indexes
    localparam logic [1:0] CFG_IMM = 2'd0;
    localparam logic [1:0] CFG_MEM = 2'd1;
    localparam logic [1:0] CFG_REG = 2'd2;

    // token codes
    localparam logic [6:0] T_ERROR = 7'd0;
    localparam logic [6:0] T_END   = 7'd1;
    localparam logic [6:0] T_INT   = 7'd2;
    localparam logic [6:0] T_STR   = 7'd3;
    localparam logic [6:0] T_NOT   = 7'd4;
    localparam logic [6:0] T_AND   = 7'd5;
    localparam logic [6:0] T_LPAR  = 7'd6;
    localparam logic [6:0] T_RPAR  = 7'd7;
    localparam logic [6:0] T_COMMA = 7'd8;
    localparam logic [6:0] T_DOT   = 7'd9;
    localparam logic [6:0] T_LT    = 7'd10;
    localparam logic [6:0] T_EQ    = 7'd11;
    localparam logic [6:0] T_GT    = 7'd12;
    localparam logic [6:0] T_AT    = 7'd13;
    localparam logic [6:0] T_LBRK  = 7'd14;
    localparam logic [6:0] T_RBRK  = 7'd15;
    localparam logic [6:0] T_NEQ   = 7'd16;
    localparam logic [6:0] T_LEQ   = 7'd17;
    localparam logic [6:0] T_GEQ   = 7'd18;

    // macro names in the keyword table
    localparam logic [7:0] MAC_FALSE = 8'h80;
    localparam logic [7:0] MAC_TRUE  = 8'h81;
    localparam logic [7:0] MAC_IMM   = 8'h82;
    localparam logic [7:0] MAC_MEM   = 8'h83;
    localparam logic [7:0] MAC_REG   = 8'h84;
    localparam logic [7:0] KW_NONE   = 8'h00;

    typedef enum logic [9:0] {
        M_IDLE    = 10'b00_0000_0001,
        M_OP2     = 10'b00_0000_0010,
        M_SIGN    = 10'b00_0000_0100,
        M_ZERO    = 10'b00_0000_1000,
        M_DIGITS  = 10'b00_0001_0000,
        M_HEXNEED = 10'b00_0010_0000,
        M_STR     = 10'b00_0100_0000,
        M_ESC     = 10'b00_1000_0000,
        M_NAME    = 10'b01_0000_0000,
        M_DEAD    = 10'b10_0000_0000
    } t_mode;

    typedef struct packed {
        logic        kind;
        logic [6:0]  token_code;
        logic [63:0] token_value;
        logic [7:0]  text_byte;
        logic        last;
    } t_res;

    typedef struct packed {
        t_mode            mode;
        logic [7:0]       pend;
        logic             neg;
        logic             hex;
        logic [63:0]      mag;
        logic [LEN_W-1:0] len;
    } t_lex;

    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_push;

    typedef struct packed {
        logic [KEY_W-1:0]  txt;
        logic [KLEN_W-1:0] len;
        logic [7:0]        code;
    } t_kw;

    localparam int KW_COUNT = 62;

    localparam t_kw KW_TABLE [KW_COUNT] = '{
        '{"FALSE", 5, MAC_FALSE}, '{"IMM", 3, MAC_IMM}, '{"MEM", 3, MAC_MEM},
        '{"REG", 3, MAC_REG}, '{"TRUE", 4, MAC_TRUE},
        '{"addr", 4, 19}, '{"address", 7, 19}, '{"after", 5, 20}, '{"asm", 3, 21},
        '{"base", 4, 22}, '{"before", 6, 23}, '{"call", 4, 24}, '{"clean", 5, 25},
        '{"count", 5, 26}, '{"dst", 3, 27}, '{"false", 5, 28}, '{"imm", 3, 29},
        '{"instr", 5, 30}, '{"jump", 4, 31}, '{"len", 3, 32}, '{"length", 6, 32},
        '{"mem", 3, 33}, '{"mnemonic", 8, 34}, '{"naked", 5, 35}, '{"next", 4, 36},
        '{"offset", 6, 37}, '{"op", 2, 38}, '{"passthru", 8, 39},
        '{"plugin", 6, 40}, '{"print", 5, 41}, '{"r10", 3, 42}, '{"r11", 3, 43},
        '{"r12", 3, 44}, '{"r13", 3, 45}, '{"r14", 3, 46}, '{"r15", 3, 47},
        '{"r8", 2, 48}, '{"r9", 2, 49}, '{"random", 6, 50}, '{"rax", 3, 51},
        '{"rbp", 3, 52}, '{"rbx", 3, 53}, '{"rcx", 3, 54}, '{"rdi", 3, 55},
        '{"rdx", 3, 56}, '{"read", 4, 57}, '{"reg", 3, 58}, '{"replace", 7, 59},
        '{"return", 6, 60}, '{"rflags", 6, 61}, '{"rip", 3, 62}, '{"rsi", 3, 63},
        '{"rsp", 3, 64}, '{"size", 4, 65}, '{"src", 3, 66},
        '{"staticAddr", 10, 67}, '{"target", 6, 68}, '{"trampoline", 10, 69},
        '{"trap", 4, 70}, '{"true", 4, 71}, '{"type", 4, 72}, '{"write", 5, 73}
    };

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // digit value, bit 4 set when c is not a digit of the base
    function automatic logic [4:0] f_digit(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        d = 5'd16;
        if (f_is_digit(c)) d = 5'(c - "0");
        else if (hex && c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
        else if (hex && c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
        return d;
    endfunction

    function automatic logic [6:0] f_single_op(input logic [7:0] c);
        logic [6:0] code;
        case (c)
            "!":     code = T_NOT;
            "&":     code = T_AND;
            "(":     code = T_LPAR;
            ")":     code = T_RPAR;
            ",":     code = T_COMMA;
            ".":     code = T_DOT;
            "<":     code = T_LT;
            "=":     code = T_EQ;
            ">":     code = T_GT;
            "@":     code = T_AT;
            "[":     code = T_LBRK;
            default: code = T_RBRK;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] f_kw_code(input logic [KEY_W-1:0] key,
                                             input logic [KLEN_W-1:0] len);
        logic [7:0] code;
        code = KW_NONE;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (KW_TABLE[k].txt == key && KW_TABLE[k].len == len) code = KW_TABLE[k].code;
        end
        return code;
    endfunction

    function automatic t_res f_tok(input logic [6:0] code, input logic [63:0] value);
        t_res r;
        r = '{kind: 1'b1, token_code: code, token_value: value, text_byte: 8'd0,
              last: 1'b0};
        return r;
    endfunction

    function automatic t_res f_txt(input logic [7:0] b);
        t_res r;
        r = '{kind: 1'b0, token_code: T_ERROR, token_value: 64'd0, text_byte: b,
              last: 1'b0};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acl_ch_if.sv
//------------------------------------------------------------------------------
// acl_ch_if
// Character request channel.
//------------------------------------------------------------------------------
`default_nettype none

interface acl_ch_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

FILE: rtl/acl_res_if.sv
//------------------------------------------------------------------------------
// acl_res_if
// Result request channel.
//------------------------------------------------------------------------------
`default_nettype none

interface acl_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  token_code;
    logic [63:0] token_value;
    logic [7:0]  text_byte;
    logic        last;
    modport source (output valid, output kind, output token_code, output token_value,
                    output text_byte, output last, input ready);
    modport sink   (input valid, input kind, input token_code, input token_value,
                    input text_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/acl_cfg_if.sv
//------------------------------------------------------------------------------
// acl_cfg_if
// Configuration write channel.
//------------------------------------------------------------------------------
`default_nettype none

interface acl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/acl_lexer.sv
//------------------------------------------------------------------------------
// acl_lexer
// Lexer state, name buffer and the per-character step logic.
//------------------------------------------------------------------------------
`default_nettype none

module acl_lexer
    import acl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_fire,
    input  wire  [7:0]  i_ch,
    input  wire  [7:0]  i_imm_code,
    input  wire  [7:0]  i_mem_code,
    input  wire  [7:0]  i_reg_code,
    output t_push       o_push
);

    typedef struct packed {
        logic em;
        t_res r;
        t_lex st;
        logic nbw;
    } t_start;

    t_lex                r_st;
    t_lex                n_st;
    logic [7:0]          r_nb [KEYWORD_MAX_LEN];
    logic                nb_we;
    logic [NB_IDX_W-1:0] nb_idx;

    function automatic t_lex f_accum(input t_lex s, input logic [3:0] d);
        t_lex       o;
        logic [67:0] w;
        o = s;
        if (s.hex) w = {s.mag, 4'd0} + 68'(d);
        else       w = {1'b0, s.mag, 3'd0} + {3'd0, s.mag, 1'b0} + 68'(d);
        o.mag = (|w[67:64]) ? '1 : w[63:0];
        o.len = s.len + 1'b1;
        return o;
    endfunction

    function automatic t_start f_start(input logic [7:0] c, input t_lex s);
        t_start o;
        o.em       = 1'b0;
        o.r        = f_tok(T_ERROR, 64'd0);
        o.nbw      = 1'b0;
        o.st       = s;
        o.st.len   = '0;
        o.st.mag   = 64'd0;
        o.st.neg   = 1'b0;
        o.st.hex   = 1'b0;
        o.st.mode  = M_IDLE;
        if (c == 8'd0) begin
            o.em = 1'b1;
            o.r  = f_tok(T_END, 64'd0);
        end else if (f_is_space(c)) begin
            o.em = 1'b0;
        end else if (c == "[" || c == "]" || c == "@" || c == "," || c == "("
                     || c == ")" || c == "&" || c == ".") begin
            o.em = 1'b1;
            o.r  = f_tok(f_single_op(c), 64'd0);
        end else if (c == "!" || c == "<" || c == ">" || c == "=") begin
            o.st.pend = c;
            o.st.mode = M_OP2;
        end else if (c == "-" || c == "+") begin
            o.st.neg  = (c == "-");
            o.st.len  = LEN_W'(1);
            o.st.mode = M_SIGN;
        end else if (c == 8'h22) begin
            o.st.mode = M_STR;
        end else if (f_is_digit(c)) begin
            o.st.len  = LEN_W'(1);
            o.st.mag  = {56'd0, c - "0"};
            o.st.mode = (c == "0") ? M_ZERO : M_DIGITS;
        end else if (f_is_alpha(c) || c == "_") begin
            o.nbw     = 1'b1;
            o.st.len  = LEN_W'(1);
            o.st.mode = M_NAME;
            o.em      = 1'b1;
            o.r       = f_txt(c);
        end else begin
            o.em      = 1'b1;
            o.r       = f_tok(T_ERROR, 64'd0);
            o.st.mode = M_DEAD;
        end
        return o;
    endfunction

    // keyword lookup over the buffered name
    logic [KEY_W-1:0] kw_key;
    logic [7:0]       kw_code;
    t_res             name_tok;

    always_comb begin
        kw_key = '0;
        for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            if (LEN_W'(i) < r_st.len) kw_key = {kw_key[KEY_W-9:0], r_nb[i]};
        end
        kw_code = (r_st.len <= LEN_W'(KEYWORD_MAX_LEN))
                  ? f_kw_code(kw_key, KLEN_W'(r_st.len)) : KW_NONE;
        case (kw_code)
            KW_NONE:   name_tok = f_tok(T_STR, 64'(r_st.len));
            MAC_FALSE: name_tok = f_tok(T_INT, 64'd0);
            MAC_TRUE:  name_tok = f_tok(T_INT, 64'd1);
            MAC_IMM:   name_tok = f_tok(T_INT, 64'(i_imm_code));
            MAC_MEM:   name_tok = f_tok(T_INT, 64'(i_mem_code));
            MAC_REG:   name_tok = f_tok(T_INT, 64'(i_reg_code));
            default:   name_tok = f_tok(kw_code[6:0], 64'd0);
        endcase
    end

    // step
    logic       e0, e1, do_start, do_fail;
    t_res       r0, r1;
    t_start     sr;
    logic [4:0] dg;
    logic [7:0] esc_c;
    logic [63:0] int_val;

    always_comb begin
        n_st     = r_st;
        e0       = 1'b0;
        e1       = 1'b0;
        r0       = f_tok(T_ERROR, 64'd0);
        r1       = f_tok(T_ERROR, 64'd0);
        do_start = 1'b0;
        do_fail  = 1'b0;
        nb_we    = 1'b0;
        nb_idx   = '0;
        dg       = f_digit(i_ch, r_st.hex);
        int_val  = r_st.neg ? (64'd0 - r_st.mag) : r_st.mag;
        esc_c    = i_ch;
        if (i_ch == "n")      esc_c = 8'h0A;
        else if (i_ch == "t") esc_c = 8'h09;
        else if (i_ch == "r") esc_c = 8'h0D;
        sr       = f_start(i_ch, r_st);

        case (r_st.mode)
            M_OP2: begin
                if (i_ch == "=") begin
                    e0 = 1'b1;
                    case (r_st.pend)
                        "!":     r0 = f_tok(T_NEQ, 64'd0);
                        "<":     r0 = f_tok(T_LEQ, 64'd0);
                        ">":     r0 = f_tok(T_GEQ, 64'd0);
                        default: r0 = f_tok(T_EQ, 64'd0);
                    endcase
                    n_st.mode = M_IDLE;
                end else begin
                    e0       = 1'b1;
                    r0       = f_tok(f_single_op(r_st.pend), 64'd0);
                    do_start = 1'b1;
                end
            end
            M_SIGN: begin
                if (f_is_digit(i_ch)) begin
                    n_st.mag  = {56'd0, i_ch - "0"};
                    n_st.len  = r_st.len + 1'b1;
                    n_st.mode = (i_ch == "0") ? M_ZERO : M_DIGITS;
                end else begin
                    do_fail = 1'b1;
                end
            end
            M_ZERO: begin
                if (i_ch == "x") begin
                    n_st.hex  = 1'b1;
                    n_st.len  = r_st.len + 1'b1;
                    n_st.mode = M_HEXNEED;
                end else if (!dg[4]) begin
                    n_st      = f_accum(r_st, dg[3:0]);
                    n_st.mode = M_DIGITS;
                end else begin
                    e0       = 1'b1;
                    r0       = f_tok(T_INT, int_val);
                    do_start = 1'b1;
                end
            end
            M_HEXNEED: begin
                if (!dg[4]) begin
                    n_st      = f_accum(r_st, dg[3:0]);
                    n_st.mode = M_DIGITS;
                end else begin
                    do_fail = 1'b1;
                end
            end
            M_DIGITS: begin
                if (!dg[4]) begin
                    if (r_st.len >= LEN_LIMIT) do_fail = 1'b1;
                    else                       n_st = f_accum(r_st, dg[3:0]);
                end else begin
                    e0       = 1'b1;
                    r0       = f_tok(T_INT, int_val);
                    do_start = 1'b1;
                end
            end
            M_STR, M_ESC: begin
                if (r_st.mode == M_STR && i_ch == 8'h22) begin
                    e0        = 1'b1;
                    r0        = f_tok(T_STR, 64'(r_st.len));
                    n_st.mode = M_IDLE;
                end else if (r_st.mode == M_STR && i_ch == 8'h5C) begin
                    n_st.mode = M_ESC;
                end else if (i_ch == 8'd0 || r_st.len >= LEN_LIMIT) begin
                    do_fail = 1'b1;
                end else begin
                    n_st.len  = r_st.len + 1'b1;
                    n_st.mode = M_STR;
                    e0        = 1'b1;
                    r0        = f_txt((r_st.mode == M_ESC) ? esc_c : i_ch);
                end
            end
            M_NAME: begin
                if (f_is_alpha(i_ch) || f_is_digit(i_ch) || i_ch == "_") begin
                    if (r_st.len >= LEN_LIMIT) begin
                        do_fail = 1'b1;
                    end else begin
                        nb_we    = (r_st.len < LEN_W'(KEYWORD_MAX_LEN));
                        nb_idx   = r_st.len[NB_IDX_W-1:0];
                        n_st.len = r_st.len + 1'b1;
                        e0       = 1'b1;
                        r0       = f_txt(i_ch);
                    end
                end else begin
                    e0       = 1'b1;
                    r0       = name_tok;
                    do_start = 1'b1;
                end
            end
            M_DEAD: begin
                if (i_ch == 8'd0) begin
                    e0        = 1'b1;
                    r0        = f_tok(T_END, 64'd0);
                    n_st.mode = M_IDLE;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        if (do_fail) begin
            e0 = 1'b1;
            r0 = f_tok(T_ERROR, 64'd0);
            if (i_ch == 8'd0) begin
                e1        = 1'b1;
                r1        = f_tok(T_END, 64'd0);
                n_st.mode = M_IDLE;
            end else begin
                n_st.mode = M_DEAD;
            end
        end

        if (do_start) begin
            n_st = sr.st;
            e1   = sr.em;
            r1   = sr.r;
            if (sr.nbw) begin
                nb_we  = 1'b1;
                nb_idx = '0;
            end
        end

        // pack results into the leading slots and flag the final one
        o_push.v0 = e0 | e1;
        o_push.v1 = e0 & e1;
        o_push.r0 = e0 ? r0 : r1;
        o_push.r1 = r1;
        if (e0 & e1) o_push.r1.last = 1'b1;
        else         o_push.r0.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode <= M_IDLE;
            r_st.pend <= 8'd0;
            r_st.neg  <= 1'b0;
            r_st.hex  <= 1'b0;
            r_st.mag  <= 64'd0;
            r_st.len  <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && nb_we) begin
            r_nb[nb_idx] <= i_ch;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acl_res_fifo.sv
//------------------------------------------------------------------------------
// acl_res_fifo
// Four-entry result queue, up to two pushes and one pop per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module acl_res_fifo
    import acl_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push_en,
    input  t_push  i_push,
    output logic   o_room2,
    output logic   o_valid,
    output t_res   o_res,
    input  wire    i_pop
);

    t_res       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       wr0, wr1, rd;

    assign wr0     = i_push_en & i_push.v0;
    assign wr1     = i_push_en & i_push.v1;
    assign o_valid = (r_cnt != 3'd0);
    assign rd      = o_valid & i_pop;
    assign o_room2 = (r_cnt <= 3'd2);
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr0) r_mem[r_wp] <= i_push.r0;
        if (wr1) r_mem[r_wp + 2'd1] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + {1'b0, wr0} + {1'b0, wr1};
            r_rp  <= r_rp + {1'b0, rd};
            r_cnt <= r_cnt + {2'd0, wr0} + {2'd0, wr1} - {2'd0, rd};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/action_string_lexer_core.sv
//------------------------------------------------------------------------------
// action_string_lexer_core
// Character-serial tokenizer for zero-terminated action strings.
//
// Usage:
//   i_in   : one character per request; a zero byte ends the string.
//   o_res  : echoed text bytes (kind 0) and completed tokens (kind 1);
//            last marks the final result caused by a character.
//   i_cfg  : writes the IMM, MEM and REG type codes (index 0, 1, 2);
//            always ready, write only while the lexer is idle.
// Path: a character is held in an input register, stepped through the
//   lexer once the result queue has room, and its results are written
//   into the result queue, whose head drives o_res.
// Throughput: one character per cycle. The lexer step takes a character
//   whenever the four-entry result queue has room for two results, so a
//   stream that yields at most one result per character runs at full rate;
//   characters that yield two results are paced by the output port.
// Reset: synchronous, active low; lexer idle between tokens, type codes 1,
//   2 and 3, input register and result queue empty.
// Stall: when o_res is held off the queue fills, the step stops and the
//   input register holds; i_in.ready then drops. Nothing is lost.
//------------------------------------------------------------------------------
`default_nettype none

module action_string_lexer_core
    import acl_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    acl_ch_if.sink     i_in,
    acl_res_if.source  o_res,
    acl_cfg_if.sink    i_cfg
);

    logic       r_in_vld;
    logic [7:0] r_ch;
    logic [7:0] r_imm;
    logic [7:0] r_mem;
    logic [7:0] r_reg;
    logic       room2;
    logic       fire;
    logic       in_take;
    t_push      push;
    t_res       head;

    // step the held character when the queue can take both possible results
    assign fire       = r_in_vld & room2;
    assign i_in.ready = ~r_in_vld | fire;
    assign in_take    = i_in.valid & i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // hold the payload until the step consumes it
    always_ff @(posedge i_clk) begin
        if (in_take) r_ch <= i_in.ch;
    end

    // type code registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imm <= 8'd1;
            r_mem <= 8'd2;
            r_reg <= 8'd3;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMM: r_imm <= i_cfg.data;
                CFG_MEM: r_mem <= i_cfg.data;
                CFG_REG: r_reg <= i_cfg.data;
                default: ;
            endcase
        end
    end

    acl_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_ch       (r_ch),
        .i_imm_code (r_imm),
        .i_mem_code (r_mem),
        .i_reg_code (r_reg),
        .o_push     (push)
    );

    acl_res_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (fire),
        .i_push    (push),
        .o_room2   (room2),
        .o_valid   (o_res.valid),
        .o_res     (head),
        .i_pop     (o_res.ready)
    );

    assign o_res.kind        = head.kind;
    assign o_res.token_code  = head.token_code;
    assign o_res.token_value = head.token_value;
    assign o_res.text_byte   = head.text_byte;
    assign o_res.last        = head.last;

endmodule

`default_nettype wire
